/* src/sfd_pkg.sv */
// shared constants, state encoding and controller/datapath interface types
`default_nettype none
package sfd_pkg;

    localparam int BUF_BYTES = 64;
    localparam int ADDR_W    = $clog2(BUF_BYTES);
    localparam int LEN_W     = 6;

    localparam logic [7:0] SYNC_A   = 8'h55;
    localparam logic [7:0] SYNC_B   = 8'hAA;
    localparam logic [7:0] SYNC_SUM = 8'hFF;
    localparam logic [7:0] MAX_LEN  = 8'(BUF_BYTES - 1);

    typedef enum logic [3:0] {
        ST_HEAD1,
        ST_HEAD2,
        ST_TYPE,
        ST_LEN,
        ST_PAYLOAD,
        ST_CHECK,
        ST_EMIT_READ,
        ST_EMIT_LOAD,
        ST_EMIT_EMPTY
    } state_t;

    typedef struct packed {
        logic sum_init;
        logic sum_add;
        logic len_load;
        logic fill_clear;
        logic fill_write;
        logic emit_clear;
        logic rd_issue;
        logic out_load_data;
        logic out_load_empty;
    } cmd_t;

    typedef struct packed {
        logic is_sync_a;
        logic is_sync_b;
        logic rx_len_big;
        logic rx_len_zero;
        logic len_zero;
        logic fill_done;
        logic sum_match;
        logic emit_last;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

/* src/sfd_ctrl.sv */
// parser and emit sequencer state machine
`default_nettype none
module sfd_ctrl
    import sfd_pkg::*;
(
    input  wire  clk,
    input  wire  rst_n,
    input  wire  rx_valid,
    output logic rx_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HEAD1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        rx_stall   = (state_reg == ST_EMIT_READ) || (state_reg == ST_EMIT_LOAD)
                     || (state_reg == ST_EMIT_EMPTY);
        accept     = rx_valid && !rx_stall;
        case (state_reg)
            ST_HEAD1:
            begin
                if (accept && sts.is_sync_a)
                begin
                    state_next = ST_HEAD2;
                end
            end
            ST_HEAD2:
            begin
                if (accept)
                begin
                    if (sts.is_sync_b)
                    begin
                        cmd.sum_init = 1'b1;
                        state_next   = ST_TYPE;
                    end
                    else if (!sts.is_sync_a)
                    begin
                        state_next = ST_HEAD1;
                    end
                end
            end
            ST_TYPE:
            begin
                if (accept)
                begin
                    cmd.sum_add = 1'b1;
                    state_next  = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (accept)
                begin
                    if (sts.rx_len_big)
                    begin
                        state_next = ST_HEAD1;
                    end
                    else
                    begin
                        cmd.sum_add  = 1'b1;
                        cmd.len_load = 1'b1;
                        if (sts.rx_len_zero)
                        begin
                            state_next = ST_CHECK;
                        end
                        else
                        begin
                            cmd.fill_clear = 1'b1;
                            state_next     = ST_PAYLOAD;
                        end
                    end
                end
            end
            ST_PAYLOAD:
            begin
                if (accept)
                begin
                    cmd.sum_add    = 1'b1;
                    cmd.fill_write = 1'b1;
                    if (sts.fill_done)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (accept)
                begin
                    if (!sts.sum_match)
                    begin
                        state_next = ST_HEAD1;
                    end
                    else if (sts.len_zero)
                    begin
                        state_next = ST_EMIT_EMPTY;
                    end
                    else
                    begin
                        cmd.emit_clear = 1'b1;
                        state_next     = ST_EMIT_READ;
                    end
                end
            end
            ST_EMIT_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_EMIT_LOAD;
            end
            ST_EMIT_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load_data = 1'b1;
                    state_next = sts.emit_last ? ST_HEAD1 : ST_EMIT_READ;
                end
            end
            ST_EMIT_EMPTY:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load_empty = 1'b1;
                    state_next         = ST_HEAD1;
                end
            end
            default:
            begin
                state_next = ST_HEAD1;
            end
        endcase
    end

endmodule
`default_nettype wire

/* src/sfd_datapath.sv */
// checksum, length, payload buffer and output register
`default_nettype none
module sfd_datapath
    import sfd_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire  [7:0]       rx_byte,
    input  cmd_t             cmd,
    output sts_t             sts,
    output logic             res_valid,
    input  wire              res_stall,
    output logic [7:0]       payload_byte,
    output logic [LEN_W-1:0] frame_length,
    output logic             empty_frame,
    output logic             last_of_frame
);

    logic [7:0]        mem [BUF_BYTES];
    logic [7:0]        sum_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [ADDR_W-1:0] fill_reg;
    logic [ADDR_W-1:0] emit_reg;
    logic [7:0]        rd_data_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_empty_reg;
    logic              out_last_reg;

    assign sts.is_sync_a   = (rx_byte == SYNC_A);
    assign sts.is_sync_b   = (rx_byte == SYNC_B);
    assign sts.rx_len_big  = (rx_byte > MAX_LEN);
    assign sts.rx_len_zero = (rx_byte == 8'd0);
    assign sts.len_zero    = (len_reg == '0);
    assign sts.fill_done   = ((ADDR_W+1)'(fill_reg) + (ADDR_W+1)'(1))
                             >= (ADDR_W+1)'(len_reg);
    assign sts.sum_match   = (sum_reg == rx_byte);
    assign sts.emit_last   = ((ADDR_W+1)'(emit_reg) + (ADDR_W+1)'(1))
                             == (ADDR_W+1)'(len_reg);
    assign sts.out_free    = !out_valid_reg || !res_stall;

    // payload buffer, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.fill_write)
        begin
            mem[fill_reg] <= rx_byte;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[emit_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            len_reg  <= '0;
            fill_reg <= '0;
            emit_reg <= '0;
        end
        else
        begin
            if (cmd.sum_init)
            begin
                sum_reg <= SYNC_SUM;
            end
            else if (cmd.sum_add)
            begin
                sum_reg <= sum_reg + rx_byte;
            end
            if (cmd.len_load)
            begin
                len_reg <= rx_byte[LEN_W-1:0];
            end
            if (cmd.fill_clear)
            begin
                fill_reg <= '0;
            end
            else if (cmd.fill_write)
            begin
                fill_reg <= fill_reg + ADDR_W'(1);
            end
            if (cmd.emit_clear)
            begin
                emit_reg <= '0;
            end
            else if (cmd.out_load_data)
            begin
                emit_reg <= emit_reg + ADDR_W'(1);
            end
        end
    end

    // output register, freed when the receiver takes the beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load_data || cmd.out_load_empty)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load_data)
        begin
            out_byte_reg  <= rd_data_reg;
            out_len_reg   <= len_reg;
            out_empty_reg <= 1'b0;
            out_last_reg  <= sts.emit_last;
        end
        else if (cmd.out_load_empty)
        begin
            out_byte_reg  <= 8'd0;
            out_len_reg   <= '0;
            out_empty_reg <= 1'b1;
            out_last_reg  <= 1'b1;
        end
    end

    assign res_valid     = out_valid_reg;
    assign payload_byte  = out_byte_reg;
    assign frame_length  = out_len_reg;
    assign empty_frame   = out_empty_reg;
    assign last_of_frame = out_last_reg;

endmodule
`default_nettype wire

/* src/sum8_frame_deframer_unit.sv */
// top level of the sum8 frame deframer
// usage:
//   rx channel: one received byte per beat (rx_valid, rx_stall, rx_byte)
//   res channel: one payload byte per beat with frame_length, empty_frame
//   and last_of_frame (res_valid, res_stall)
//   frame format: 0x55 0xAA type length payload[length] check, where check
//   is the 8-bit wrapping sum of all bytes before it
//   header, type, length and payload bytes are taken one per cycle; the
//   checksum is accumulated as bytes arrive, so the check byte is also
//   taken without a stall
//   on a match the payload is read back from the 64-byte buffer: each byte
//   takes a buffer read and then an output load, so rx_stall stays high
//   through the whole readback plus any receiver stalls; an empty frame
//   gives one beat with empty_frame set, loaded once the output register
//   is free after its check byte is accepted
//   the first payload byte reaches the output through the registered buffer read
//   lengths above 63 drop the frame at once; a mismatch emits nothing
//   a stalled receiver freezes the output register and the read sequencer,
//   and rx_stall stays high until the last beat of the run is loaded; after
//   that the rx side takes bytes of the next frame while the last beat waits
//   reset puts the parser back to hunting for 0x55 and empties the output
`default_nettype none
module sum8_frame_deframer_unit
    import sfd_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        rx_valid,
    output logic       rx_stall,
    input  wire  [7:0] rx_byte,
    output logic       res_valid,
    input  wire        res_stall,
    output logic [7:0] payload_byte,
    output logic [5:0] frame_length,
    output logic       empty_frame,
    output logic       last_of_frame
);

    // command and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    sfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    sfd_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_byte       (rx_byte),
        .cmd           (cmd),
        .sts           (sts),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .payload_byte  (payload_byte),
        .frame_length  (frame_length),
        .empty_frame   (empty_frame),
        .last_of_frame (last_of_frame)
    );

endmodule
`default_nettype wire

/* src/sfd_checker.sv */
// port-level checks for the frame deframer, bound to the top level
`default_nettype none
module sfd_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       res_valid,
    input wire       res_stall,
    input wire [7:0] payload_byte,
    input wire [5:0] frame_length,
    input wire       empty_frame,
    input wire       last_of_frame
);

    // a stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(payload_byte)
        && $stable(last_of_frame))
        else $error("stalled result beat changed");

    // an empty frame is a single beat of length zero
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && empty_frame |-> last_of_frame && frame_length == 6'd0
        && payload_byte == 8'd0)
        else $error("empty frame beat malformed");

    // a payload beat always carries a nonzero length
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !empty_frame |-> frame_length != 6'd0)
        else $error("payload beat with zero length");

    // a frame keeps its length across its beats
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && !last_of_frame ##1 res_valid
        |-> frame_length == $past(frame_length))
        else $error("frame length changed inside a frame");

endmodule

bind sum8_frame_deframer_unit sfd_checker u_sfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .payload_byte  (payload_byte),
    .frame_length  (frame_length),
    .empty_frame   (empty_frame),
    .last_of_frame (last_of_frame)
);
`default_nettype wire

/* tb/sv/sum8_frame_deframer_unit_tb.sv */
// testbench for the sum8 frame deframer: directed frames, random byte streams, scoreboard
`timescale 1ns / 1ps
module sum8_frame_deframer_unit_tb
    import sfd_pkg::*;
();

    localparam int CYCLE_LIMIT = 1000000;

    typedef logic [7:0] byte_q_t[$];

    // one result beat as the block should present it
    typedef struct packed {
        logic [7:0] payload;
        logic [5:0] length;
        logic       is_empty;
        logic       is_last;
    } res_beat_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       rx_valid;
    logic       rx_stall;
    logic [7:0] rx_byte;
    logic       res_valid;
    logic       res_stall = 1'b0;
    logic [7:0] payload_byte;
    logic [5:0] frame_length;
    logic       empty_frame;
    logic       last_of_frame;

    // idle and stall odds in percent, changed per phase
    int idle_pct  = 0;
    int stall_pct = 0;

    int bytes_sent     = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    // shadow parser state
    state_t     parse_state;
    logic [7:0] seen_type;
    logic [7:0] seen_len;
    int         fill_count;
    logic [7:0] payload_copy [BUF_BYTES];

    // beats still owed by the block, oldest first
    res_beat_t  expected_beats[$];

    sum8_frame_deframer_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_valid      (rx_valid),
        .rx_stall      (rx_stall),
        .rx_byte       (rx_byte),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .payload_byte  (payload_byte),
        .frame_length  (frame_length),
        .empty_frame   (empty_frame),
        .last_of_frame (last_of_frame)
    );

    always #1 clk = ~clk;

    // run-away guard
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge clk)
    begin
        res_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 100)
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
        mismatch_count = mismatch_count + 1;
    endtask

    // advance the shadow parser by one accepted byte and queue any beats it owes
    task automatic parse_rx_byte(input logic [7:0] b);
        logic [7:0] sum;
        res_beat_t  beat;
        case (parse_state)
            ST_HEAD2:
            begin
                // a repeated sync byte keeps waiting for the second header byte
                if (b == SYNC_B)
                    parse_state = ST_TYPE;
                else if (b != SYNC_A)
                    parse_state = ST_HEAD1;
            end
            ST_TYPE:
            begin
                seen_type   = b;
                parse_state = ST_LEN;
            end
            ST_LEN:
            begin
                seen_len = b;
                // oversize length drops the frame with no check byte taken
                if (b > MAX_LEN)
                    parse_state = ST_HEAD1;
                else if (b == 8'h00)
                    parse_state = ST_CHECK;
                else
                begin
                    fill_count  = 0;
                    parse_state = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD:
            begin
                if (fill_count < BUF_BYTES)
                    payload_copy[fill_count] = b;
                fill_count = fill_count + 1;
                if (fill_count >= seen_len)
                    parse_state = ST_CHECK;
            end
            ST_CHECK:
            begin
                sum = SYNC_SUM + seen_type + seen_len;
                for (int i = 0; i < seen_len; i++)
                    sum = sum + payload_copy[i];
                if (sum == b)
                begin
                    if (seen_len == 8'h00)
                    begin
                        beat = '{payload: 8'h00, length: 6'd0, is_empty: 1'b1, is_last: 1'b1};
                        expected_beats.push_back(beat);
                    end
                    else
                    begin
                        for (int i = 0; i < seen_len; i++)
                        begin
                            beat.payload  = payload_copy[i];
                            beat.length   = seen_len[5:0];
                            beat.is_empty = 1'b0;
                            beat.is_last  = (i + 1 == seen_len);
                            expected_beats.push_back(beat);
                        end
                    end
                end
                parse_state = ST_HEAD1;
            end
            default:
            begin
                parse_state = (b == SYNC_A) ? ST_HEAD2 : ST_HEAD1;
            end
        endcase
    endtask

    // result checker: every accepted beat against the oldest expectation
    always @(posedge clk)
    begin
        res_beat_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_beats.size() == 0)
                report_mismatch("unexpected beat, payload_byte", payload_byte, -1);
            else
            begin
                want = expected_beats.pop_front();
                if (payload_byte !== want.payload)
                    report_mismatch("payload_byte", payload_byte, want.payload);
                if (frame_length !== want.length)
                    report_mismatch("frame_length", frame_length, want.length);
                if (empty_frame !== want.is_empty)
                    report_mismatch("empty_frame", empty_frame, want.is_empty);
                if (last_of_frame !== want.is_last)
                    report_mismatch("last_of_frame", last_of_frame, want.is_last);
            end
        end
    end

    // one rx beat; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        parse_rx_byte(b);
        bytes_sent = bytes_sent + 1;
        @(negedge clk);
    endtask

    // header, type, length, body and check byte; corrupt spoils the check byte
    task automatic send_frame(input logic [7:0] ftype, input byte_q_t body,
                              input int extra_sync, input bit corrupt);
        logic [7:0] check;
        check = SYNC_SUM + ftype + 8'(body.size());
        foreach (body[i])
            check = check + body[i];
        if (corrupt)
            check = check ^ 8'($urandom_range(1, 255));
        repeat (extra_sync)
            send_byte(SYNC_A);
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(ftype);
        send_byte(8'(body.size()));
        foreach (body[i])
            send_byte(body[i]);
        send_byte(check);
    endtask

    function automatic byte_q_t random_body(input int n);
        byte_q_t body;
        for (int i = 0; i < n; i++)
            body.push_back(8'($urandom_range(0, 255)));
        return body;
    endfunction

    // zero length goes straight to the check byte and gives one empty beat
    task automatic test_empty_frame();
        byte_q_t none;
        send_frame(8'hFF, none, 0, 1'b0);
    endtask

    // repeated 0x55 before 0xAA, payload at both byte extremes
    task automatic test_repeated_sync();
        byte_q_t body;
        body.push_back(8'h00);
        body.push_back(8'hFF);
        send_frame(8'h00, body, 1, 1'b0);
    endtask

    // a stray byte in place of 0xAA sends the parser back to hunting
    task automatic test_bad_header();
        send_byte(SYNC_A);
        send_byte(8'h3C);
    endtask

    // largest length value drops the frame right after the length byte
    task automatic test_oversize_length();
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    // checksum mismatch emits nothing
    task automatic test_bad_checksum();
        byte_q_t none;
        send_frame(8'h5A, none, 0, 1'b1);
    endtask

    // longest payload the block allows
    task automatic test_max_length();
        send_frame(8'($urandom_range(0, 255)), random_body(BUF_BYTES - 1), 0, 1'b0);
    endtask

    // hold the sender off until the block has delivered everything it owes
    task automatic test_drain_pause();
        send_frame(8'($urandom_range(0, 255)), random_body($urandom_range(1, 8)), 0, 1'b0);
        rx_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_beats.size() != 0);
        send_frame(8'($urandom_range(0, 255)), random_body($urandom_range(1, 8)), 0, 1'b0);
    endtask

    // mostly well-formed frames with random content, plus noise and broken frames
    task automatic test_random_traffic(input int quota);
        int start_count;
        int pick;
        int len;
        start_count = bytes_sent;
        while (bytes_sent - start_count < quota)
        begin
            pick = $urandom_range(0, 99);
            len  = $urandom_range(0, 9);
            if (len == 9)
                len = $urandom_range(9, BUF_BYTES - 1);
            if (pick < 75)
                send_frame(8'($urandom_range(0, 255)), random_body(len),
                           ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0, 1'b0);
            else if (pick < 85)
                send_frame(8'($urandom_range(0, 255)), random_body(len), 0, 1'b1);
            else if (pick < 92)
            begin
                // line noise
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(0, 255)));
            end
            else if (pick < 96)
            begin
                // header with a length above 63, which the block drops
                send_byte(SYNC_A);
                send_byte(SYNC_B);
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(BUF_BYTES, 255)));
            end
            else
            begin
                // first header byte followed by garbage
                send_byte(SYNC_A);
                send_byte(($urandom_range(0, 1) == 0) ? 8'h00 : 8'hA9);
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        rx_valid    = 1'b0;
        rx_byte     = 8'h00;
        parse_state = ST_HEAD1;
        seen_type   = 8'h00;
        seen_len    = 8'h00;
        fill_count  = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed frames with no idling
        test_empty_frame();
        test_repeated_sync();
        test_bad_header();
        test_oversize_length();
        test_bad_checksum();

        // random traffic through each idling mix
        test_random_traffic(25);
        idle_pct  = 64;
        stall_pct = 0;
        test_random_traffic(25);
        test_drain_pause();
        idle_pct  = 0;
        stall_pct = 64;
        test_max_length();
        test_random_traffic(25);
        idle_pct  = 18;
        stall_pct = 18;
        test_random_traffic(25);
        test_max_length();
        idle_pct  = 0;
        stall_pct = 0;
        test_random_traffic(10);

        // drain: wait until nothing is owed, then wait on for strays
        rx_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_beats.size() != 0);
        repeat (40) @(negedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
